// File: rtl/bmpd_pkg.sv
package bmpd_pkg;

    localparam int ARGB_W = 32;
    localparam int IDX_W  = 24;

    localparam logic [15:0] BMP_SIGNATURE    = 16'h4D42;
    localparam logic [31:0] MIN_PIXEL_OFFSET = 32'd54;
    localparam logic [15:0] DEPTH_24         = 16'd24;
    localparam logic [15:0] DEPTH_32         = 16'd32;
    localparam logic [7:0]  ALPHA_OPAQUE     = 8'hFF;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_SKIP    = 3'd1,
        PH_PIXELS  = 3'd2,
        PH_PADDING = 3'd3,
        PH_DONE    = 3'd4,
        PH_ERROR   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_PIXEL     = 3'd0,
        ST_DONE      = 3'd1,
        ST_BAD_SIG   = 3'd2,
        ST_BAD_DEPTH = 3'd3,
        ST_TRUNC     = 3'd4,
        ST_BAD_SIZE  = 3'd5
    } status_t;

    typedef struct packed {
        logic [ARGB_W-1:0] argb;
        logic [IDX_W-1:0]  index;
        status_t           status;
    } result_t;

endpackage

// File: rtl/bmpd_parser.sv
module bmpd_parser #(
    parameter int MAX_DIM = 4096
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              end_of_file,
    output logic              res_valid,
    output bmpd_pkg::result_t res
);
    import bmpd_pkg::*;

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PROD_W = 2 * DIM_W;

    // Byte positions that complete header fields.
    localparam logic [31:0] POS_SIG    = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd21;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_DEPTH  = 32'd29;
    localparam logic [31:0] POS_LAST   = 32'd53;

    phase_t              phase_reg, phase_next;
    logic [31:0]         pos_reg, pos_next;
    logic [31:0]         gather_reg, gather_next;
    logic [31:0]         start_reg, start_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic                top_down_reg, top_down_next;
    logic                four_reg, four_next;
    logic [1:0]          comp_reg, comp_next;
    logic [23:0]         partial_reg, partial_next;
    logic [DIM_W-1:0]    column_reg, column_next;
    logic [DIM_W-1:0]    rows_reg, rows_next;
    logic [IDX_W-1:0]    row_base_reg, row_base_next;
    logic [1:0]          pad_reg, pad_next;

    logic [31:0]         shifted;
    logic [31:0]         height_mag;
    logic                hdr_err;
    status_t             hdr_code;
    logic                pix_done;
    logic [DIM_W-1:0]    column_inc;
    logic [DIM_W-1:0]    rows_inc;
    logic                row_wrap;
    logic                last_row;
    logic [PROD_W-1:0]   bottom_prod;
    logic [IDX_W-1:0]    bottom_base;
    logic [31:0]         pos_inc;

    assign shifted     = {data_byte, gather_reg[31:8]};
    assign height_mag  = shifted[31] ? (~shifted + 32'd1) : shifted;
    assign pos_inc     = pos_reg + 32'd1;
    assign pix_done    = (phase_reg == PH_PIXELS)
                      && ((four_reg && comp_reg == 2'd3) || (!four_reg && comp_reg == 2'd2));
    assign column_inc  = column_reg + DIM_W'(1);
    assign rows_inc    = rows_reg + DIM_W'(1);
    assign row_wrap    = column_inc >= width_reg;
    assign last_row    = rows_inc >= height_reg;
    // Start of the bottom row, which is the first stored row of a bottom-up image.
    assign bottom_prod = PROD_W'(height_reg - DIM_W'(1)) * PROD_W'(width_reg);
    assign bottom_base = IDX_W'(bottom_prod);

    // Header field checks, each on the byte that completes its field.
    always_comb
    begin
        hdr_err  = 1'b0;
        hdr_code = ST_PIXEL;
        if (phase_reg == PH_HEADER)
        begin
            if (pos_reg == POS_SIG && shifted[31:16] != BMP_SIGNATURE)
            begin
                hdr_err  = 1'b1;
                hdr_code = ST_BAD_SIG;
            end
            else if (pos_reg == POS_OFFSET && shifted < MIN_PIXEL_OFFSET)
            begin
                hdr_err  = 1'b1;
                hdr_code = ST_BAD_SIZE;
            end
            else if (pos_reg == POS_WIDTH
                     && (shifted == 32'd0 || shifted > 32'(MAX_DIM)))
            begin
                hdr_err  = 1'b1;
                hdr_code = ST_BAD_SIZE;
            end
            else if (pos_reg == POS_HEIGHT
                     && (height_mag == 32'd0 || height_mag > 32'(MAX_DIM)))
            begin
                hdr_err  = 1'b1;
                hdr_code = ST_BAD_SIZE;
            end
            else if (pos_reg == POS_DEPTH
                     && shifted[31:16] != DEPTH_24 && shifted[31:16] != DEPTH_32)
            begin
                hdr_err  = 1'b1;
                hdr_code = ST_BAD_DEPTH;
            end
        end
    end

    // Next state.
    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        gather_next   = gather_reg;
        start_next    = start_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        top_down_next = top_down_reg;
        four_next     = four_reg;
        comp_next     = comp_reg;
        partial_next  = partial_reg;
        column_next   = column_reg;
        rows_next     = rows_reg;
        row_base_next = row_base_reg;
        pad_next      = pad_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                gather_next = shifted;
                if (pos_reg == POS_OFFSET)
                begin
                    start_next = shifted;
                end
                if (pos_reg == POS_WIDTH && !hdr_err)
                begin
                    width_next = DIM_W'(shifted);
                end
                if (pos_reg == POS_HEIGHT)
                begin
                    if (shifted[31])
                    begin
                        top_down_next = 1'b1;
                    end
                    if (!hdr_err)
                    begin
                        height_next = DIM_W'(height_mag);
                    end
                end
                if (pos_reg == POS_DEPTH && !hdr_err)
                begin
                    four_next = (shifted[31:16] == DEPTH_32);
                end
                if (hdr_err)
                begin
                    phase_next = PH_ERROR;
                end
                else
                begin
                    pos_next = pos_inc;
                    if (pos_reg == POS_LAST)
                    begin
                        if (start_reg == MIN_PIXEL_OFFSET)
                        begin
                            phase_next    = PH_PIXELS;
                            column_next   = '0;
                            rows_next     = '0;
                            comp_next     = '0;
                            partial_next  = '0;
                            pad_next      = '0;
                            row_base_next = top_down_reg ? '0 : bottom_base;
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                pos_next = pos_inc;
                if (pos_inc == start_reg)
                begin
                    phase_next    = PH_PIXELS;
                    column_next   = '0;
                    rows_next     = '0;
                    comp_next     = '0;
                    partial_next  = '0;
                    pad_next      = '0;
                    row_base_next = top_down_reg ? '0 : bottom_base;
                end
            end
            PH_PIXELS:
            begin
                if (pix_done)
                begin
                    comp_next    = '0;
                    partial_next = '0;
                    if (row_wrap)
                    begin
                        column_next = '0;
                        rows_next   = rows_inc;
                        if (last_row)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            row_base_next = top_down_reg ? row_base_reg + IDX_W'(width_reg)
                                                         : row_base_reg - IDX_W'(width_reg);
                            pad_next = four_reg ? 2'd0 : width_reg[1:0];
                            if (!four_reg && width_reg[1:0] != 2'd0)
                            begin
                                phase_next = PH_PADDING;
                            end
                        end
                    end
                    else
                    begin
                        column_next = column_inc;
                    end
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                    case (comp_reg)
                        2'd0:    partial_next[7:0]   = data_byte;
                        2'd1:    partial_next[15:8]  = data_byte;
                        2'd2:    partial_next[23:16] = data_byte;
                        default: partial_next        = partial_reg;
                    endcase
                end
            end
            PH_PADDING:
            begin
                pad_next = pad_reg - 2'd1;
                if (pad_reg == 2'd1)
                begin
                    phase_next = PH_PIXELS;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // The last byte of a file returns everything to the reset state.
        if (end_of_file)
        begin
            phase_next    = PH_HEADER;
            pos_next      = '0;
            gather_next   = '0;
            start_next    = '0;
            width_next    = '0;
            height_next   = '0;
            top_down_next = 1'b0;
            four_next     = 1'b0;
            comp_next     = '0;
            partial_next  = '0;
            column_next   = '0;
            rows_next     = '0;
            row_base_next = '0;
            pad_next      = '0;
        end
    end

    // Result of the current byte.
    always_comb
    begin
        res_valid    = 1'b0;
        res.argb     = '0;
        res.index    = '0;
        res.status   = ST_PIXEL;
        if (hdr_err)
        begin
            res_valid  = 1'b1;
            res.status = hdr_code;
        end
        else if (pix_done)
        begin
            res_valid  = 1'b1;
            res.argb   = four_reg ? {data_byte, partial_reg}
                                  : {ALPHA_OPAQUE, data_byte, partial_reg[15:0]};
            res.index  = row_base_reg + IDX_W'(column_reg);
            res.status = (row_wrap && last_row) ? ST_DONE : ST_PIXEL;
        end

        if (end_of_file)
        begin
            if (res_valid && res.status == ST_PIXEL)
            begin
                res.status = ST_TRUNC;
                res.argb   = '0;
                res.index  = '0;
            end
            else if (!res_valid && phase_reg != PH_DONE && phase_reg != PH_ERROR
                     && !(pix_done && row_wrap && last_row))
            begin
                res_valid  = 1'b1;
                res.status = ST_TRUNC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            gather_reg   <= '0;
            start_reg    <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            top_down_reg <= 1'b0;
            four_reg     <= 1'b0;
            comp_reg     <= '0;
            partial_reg  <= '0;
            column_reg   <= '0;
            rows_reg     <= '0;
            row_base_reg <= '0;
            pad_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            gather_reg   <= gather_next;
            start_reg    <= start_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            top_down_reg <= top_down_next;
            four_reg     <= four_next;
            comp_reg     <= comp_next;
            partial_reg  <= partial_next;
            column_reg   <= column_next;
            rows_reg     <= rows_next;
            row_base_reg <= row_base_next;
            pad_reg      <= pad_next;
        end
    end

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status != ST_PIXEL && res.status != ST_DONE)
        |-> (res.argb == '0 && res.index == '0))
        else $error("error result carries pixel data");

    a_pos_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS || phase_reg == PH_PADDING)
        |-> (column_reg < width_reg && rows_reg < height_reg))
        else $error("pixel position outside the image");

    a_pad_24bit: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PADDING) |-> (!four_reg && pad_reg != 2'd0))
        else $error("row padding in a 32-bit image or with no bytes left");

    a_eof_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_of_file) |=> (phase_reg == PH_HEADER && pos_reg == '0))
        else $error("decoder did not restart after end of file");

endmodule

// File: rtl/bmpd_out_fifo.sv
module bmpd_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bmpd_pkg::result_t din,
    output logic              full,
    output logic              out_valid,
    input  logic              out_ready,
    output bmpd_pkg::result_t dout
);
    import bmpd_pkg::*;

    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign full      = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign dout      = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    head_next = din;
                end
                else
                begin
                    skid_next = din;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                head_next  = skid_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    head_next = din;
                end
                else
                begin
                    head_next = skid_reg;
                    skid_next = din;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("result pushed into a full buffer");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("buffer count out of range");

    a_hold_head: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(head_reg)))
        else $error("stalled result changed");

endmodule

// File: rtl/bmp_pixel_stream_decoder_core.sv
// Streaming BMP decoder for uncompressed 24-bit and 32-bit images. The block takes the
// file one byte per transaction on the slave stream, with tlast on the final byte, and
// parses the 14-byte file header and 40-byte info header (signature, pixel offset, width,
// signed height, bit count). Bytes up to the pixel offset are skipped, then every BGR
// or BGRA group becomes one ARGB pixel (alpha 255 for 24-bit data), sent with its
// destination index row * width + column, row 0 on top; bottom-up files are flipped and
// row padding is dropped. The master stream carries one transaction per pixel, per header
// error or per truncation, with a status code in tuser. After an error, or after the last
// pixel, bytes are ignored until tlast, and tlast always starts a new file. One byte is
// accepted every clock cycle: each byte passes an input register, the parser update, and
// a two-entry result buffer. The result is written into that buffer when the parser takes
// its byte and is then offered on the master stream. The input stalls only while a byte
// is held and that buffer is full, which takes a stall on the master side.
module bmp_pixel_stream_decoder_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_file

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] pixel_argb, [55:32] pixel_index
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import bmpd_pkg::*;

    // Input register: holds one byte until the parser takes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eof_reg;

    logic       proc_fire;
    logic       in_take;
    logic       res_valid;
    result_t    res;
    logic       buf_full;
    result_t    buf_out;

    // The parser advances whenever a byte is held and the result buffer has room,
    // whether or not that byte produces a result.
    assign proc_fire     = in_valid_reg && !buf_full;
    assign s_axis_tready = !in_valid_reg || !buf_full;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eof_reg  <= s_axis_tlast;
        end
    end

    bmpd_parser #(
        .MAX_DIM (MAX_DIM)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (proc_fire),
        .data_byte   (in_byte_reg),
        .end_of_file (in_eof_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Two-entry output buffer decouples the parser from master-side stalls.
    bmpd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (proc_fire && res_valid),
        .din       (res),
        .full      (buf_full),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dout      (buf_out)
    );

    assign m_axis_tdata = {buf_out.index, buf_out.argb};
    assign m_axis_tuser = buf_out.status;

endmodule

// File: dv/bmp_pixel_checker.sv
`timescale 1ns / 100ps

module bmp_pixel_checker #(
    parameter int MAX_DIM = 4096
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser,

    output int          mismatch_count,
    output int          results_pending
);

    import bmpd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Decoder state as the checker tracks it.
    phase_t      phase;
    logic [31:0] byte_pos;
    logic [31:0] gather;
    logic [31:0] pix_offset;
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic        top_down;
    logic        wide_pixels;
    logic [1:0]  comp_idx;
    logic [23:0] partial;
    logic [12:0] column;
    logic [12:0] rows_done;
    logic [23:0] row_base;
    logic [1:0]  pad_left;

    result_t expected_pixels[$];
    int      reported;

    task automatic clear_decoder();
        phase       = PH_HEADER;
        byte_pos    = '0;
        gather      = '0;
        pix_offset  = '0;
        img_width   = '0;
        img_height  = '0;
        top_down    = 1'b0;
        wide_pixels = 1'b0;
        comp_idx    = '0;
        partial     = '0;
        column      = '0;
        rows_done   = '0;
        row_base    = '0;
        pad_left    = '0;
    endtask

    task automatic open_pixel_data();
        phase     = PH_PIXELS;
        column    = '0;
        rows_done = '0;
        comp_idx  = '0;
        partial   = '0;
        pad_left  = '0;
        row_base  = top_down ? 24'd0
                             : 24'((32'(img_height) - 32'd1) * 32'(img_width));
    endtask

    // Works out the result, if any, that one file byte causes.
    task automatic decode_byte(input logic [7:0] data, input logic last);
        logic        emit;
        logic        bad;
        status_t     bad_code;
        result_t     res;
        logic [31:0] pos;
        logic [31:0] mag;
        logic [15:0] depth;
        emit       = 1'b0;
        bad        = 1'b0;
        bad_code   = ST_BAD_SIG;
        res.argb   = '0;
        res.index  = '0;
        res.status = ST_PIXEL;
        case (phase)
            PH_HEADER:
            begin
                pos    = byte_pos;
                gather = {data, gather[31:8]};
                if (pos == 32'd1 && gather[31:16] != BMP_SIGNATURE) begin
                    bad      = 1'b1;
                    bad_code = ST_BAD_SIG;
                end else if (pos == 32'd13) begin
                    pix_offset = gather;
                    if (gather < MIN_PIXEL_OFFSET) begin
                        bad      = 1'b1;
                        bad_code = ST_BAD_SIZE;
                    end
                end else if (pos == 32'd21) begin
                    if (gather == 32'd0 || gather > MAX_DIM) begin
                        bad      = 1'b1;
                        bad_code = ST_BAD_SIZE;
                    end else begin
                        img_width = gather[12:0];
                    end
                end else if (pos == 32'd25) begin
                    mag = gather;
                    if (mag[31]) begin
                        top_down = 1'b1;
                        mag      = -mag;
                    end
                    if (mag == 32'd0 || mag > MAX_DIM) begin
                        bad      = 1'b1;
                        bad_code = ST_BAD_SIZE;
                    end else begin
                        img_height = mag[12:0];
                    end
                end else if (pos == 32'd29) begin
                    depth = gather[31:16];
                    if (depth == DEPTH_24) begin
                        wide_pixels = 1'b0;
                    end else if (depth == DEPTH_32) begin
                        wide_pixels = 1'b1;
                    end else begin
                        bad      = 1'b1;
                        bad_code = ST_BAD_DEPTH;
                    end
                end
                if (bad) begin
                    emit       = 1'b1;
                    res.status = bad_code;
                    phase      = PH_ERROR;
                end else begin
                    byte_pos = pos + 32'd1;
                    if (pos == 32'd53) begin
                        if (pix_offset == MIN_PIXEL_OFFSET) begin
                            open_pixel_data();
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_SKIP:
            begin
                byte_pos = byte_pos + 32'd1;
                if (byte_pos == pix_offset) begin
                    open_pixel_data();
                end
            end
            PH_PIXELS:
            begin
                if (wide_pixels && comp_idx == 2'd3) begin
                    emit     = 1'b1;
                    res.argb = {data, partial};
                end else if (!wide_pixels && comp_idx == 2'd2) begin
                    emit     = 1'b1;
                    res.argb = {ALPHA_OPAQUE, data, partial[15:0]};
                end else begin
                    partial[8*comp_idx +: 8] = data;
                    comp_idx = comp_idx + 2'd1;
                end
                if (emit) begin
                    res.index = row_base + 24'(column);
                    comp_idx  = '0;
                    partial   = '0;
                    column    = column + 13'd1;
                    if (column >= img_width) begin
                        column    = '0;
                        rows_done = rows_done + 13'd1;
                        if (rows_done >= img_height) begin
                            res.status = ST_DONE;
                            phase      = PH_DONE;
                        end else begin
                            row_base = top_down ? row_base + 24'(img_width)
                                                : row_base - 24'(img_width);
                            pad_left = wide_pixels ? 2'd0 : img_width[1:0];
                            if (pad_left != 2'd0) begin
                                phase = PH_PADDING;
                            end
                        end
                    end
                end
            end
            PH_PADDING:
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0) begin
                    phase = PH_PIXELS;
                end
            end
            default:
            begin
            end
        endcase

        // End of file: a pending pixel turns into a truncation, and a file that
        // stops before its last pixel reports truncation on its own.
        if (last) begin
            if (emit && res.status == ST_PIXEL) begin
                res.argb   = '0;
                res.index  = '0;
                res.status = ST_TRUNC;
            end else if (!emit && phase != PH_DONE && phase != PH_ERROR) begin
                emit       = 1'b1;
                res.status = ST_TRUNC;
            end
            clear_decoder();
        end

        if (emit) begin
            expected_pixels.push_back(res);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n) begin
            clear_decoder();
            expected_pixels.delete();
            mismatch_count  = 0;
            results_pending = 0;
            reported        = 0;
        end else begin
            // Results first: a byte accepted at this edge cannot yet have a result.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (reported < REPORT_LIMIT) begin
                        reported++;
                        $display("%0t: unexpected result argb %h index %h status %0d",
                                 $realtime, m_axis_tdata[31:0], m_axis_tdata[55:32],
                                 m_axis_tuser);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_axis_tdata[31:0] !== want.argb ||
                        m_axis_tdata[55:32] !== want.index ||
                        m_axis_tuser !== want.status) begin
                        mismatch_count++;
                        if (reported < REPORT_LIMIT) begin
                            reported++;
                            $display("%0t: result mismatch: argb %h (exp %h) index %h (exp %h) status %0d (exp %0d)",
                                     $realtime, m_axis_tdata[31:0], want.argb,
                                     m_axis_tdata[55:32], want.index,
                                     m_axis_tuser, want.status);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
            results_pending = expected_pixels.size();
        end
    end

endmodule

// File: dv/tb_bmp_pixel_stream_decoder_core.sv
`timescale 1ns / 100ps

module tb_bmp_pixel_stream_decoder_core;

    import bmpd_pkg::*;

    localparam int MAX_DIM      = 4096;
    // Bytes to send in all; random files follow the directed ones until this is reached.
    localparam int TOTAL_ITEMS  = 1750;
    // The run is cut off when the cycle count reaches this limit.
    localparam int CYCLE_LIMIT  = 500000;
    // Idle time after the final drain, so this settles any stray output.
    localparam int DRAIN_CYCLES = 20;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int          mismatch_count;
    int          results_pending;

    // Percent of cycles in which the byte source holds back or the pixel sink stalls.
    int          gap_pct       = 10;
    int          stall_pct     = 10;
    int          cycle_count   = 0;
    int          bytes_sent    = 0;

    // The file that is currently being built and sent, first byte at index 0.
    logic [7:0]  bmp_bytes[$];

    always #5 clk = ~clk;

    bmp_pixel_stream_decoder_core #(
        .MAX_DIM (MAX_DIM)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // The checker watches both streams, predicts every result from the accepted
    // bytes and compares each result transaction against the oldest prediction.
    bmp_pixel_checker #(
        .MAX_DIM (MAX_DIM)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // The pixel sink changes its ready at the falling edge, stalling at random.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one byte on the slave stream. It is called at a falling edge and
    // returns at the falling edge after the transaction, so tvalid stays high
    // across back-to-back bytes unless a random gap is drawn.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Appends a little-endian field of the given number of bytes.
    task automatic put_le(input logic [31:0] value, input int count);
        for (int i = 0; i < count; i++) begin
            bmp_bytes.push_back(value[8*i +: 8]);
        end
    endtask

    // Sends the whole of bmp_bytes as one file, tlast on its final byte.
    task automatic send_file();
        foreach (bmp_bytes[i]) begin
            send_byte(bmp_bytes[i], i == bmp_bytes.size() - 1);
        end
        bytes_sent += bmp_bytes.size();
    endtask

    // Holds the byte source until every predicted result has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (results_pending != 0) begin
            @(negedge clk);
        end
    endtask

    // Builds and sends one BMP file. The pixel area follows the header fields
    // where they are legal; a width or height that is not legal counts as one. Rows of
    // 24-bit data are padded to a multiple of four bytes, and trail adds
    // bytes after the image. A non-negative poke_at overwrites one byte,
    // and a non-zero cut ends the file after that many bytes.
    task automatic run_file(input logic [31:0] offset, input logic [31:0] width,
                            input logic [31:0] height, input logic [15:0] depth,
                            input int trail, input int cut, input int poke_at,
                            input logic [7:0] poke_val);
        logic [31:0] mag;
        int          cols;
        int          rows;
        int          bpp;
        int          pad;
        bmp_bytes.delete();
        // File header: signature, file size, reserved words, pixel offset.
        put_le(32'(BMP_SIGNATURE), 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le(offset, 4);
        // Info header: size, width, height, planes, bit count, then fields the
        // decoder ignores, filled with random bytes.
        put_le(32'd40, 4);
        put_le(width, 4);
        put_le(height, 4);
        put_le(32'd1, 2);
        put_le(32'(depth), 2);
        repeat (24) bmp_bytes.push_back(8'($urandom));
        mag  = height[31] ? -height : height;
        cols = (width >= 1 && width <= MAX_DIM) ? int'(width) : 1;
        rows = (mag >= 1 && mag <= MAX_DIM) ? int'(mag) : 1;
        bpp  = (depth == DEPTH_32) ? 4 : 3;
        pad  = (bpp == 3) ? (4 - (3 * cols) % 4) % 4 : 0;
        if (offset > 32'd54 && offset < 32'd64) begin
            repeat (int'(offset) - 54) bmp_bytes.push_back(8'($urandom));
        end
        repeat (rows) begin
            repeat (cols * bpp) bmp_bytes.push_back(8'($urandom));
            repeat (pad) bmp_bytes.push_back(8'($urandom));
        end
        repeat (trail) bmp_bytes.push_back(8'($urandom));
        if (poke_at >= 0 && poke_at < bmp_bytes.size()) begin
            bmp_bytes[poke_at] = poke_val;
        end
        if (cut > 0) begin
            while (bmp_bytes.size() > cut) begin
                bmp_bytes.delete(bmp_bytes.size() - 1);
            end
        end
        send_file();
    endtask

    // One random file. Most are well-formed small images with random pixels and
    // random geometry; the rest are cut short, have a corrupted header byte, or
    // are plain noise.
    task automatic random_file();
        int          kind;
        logic [31:0] width;
        logic [31:0] mag;
        logic [31:0] offset;
        logic [15:0] depth;
        int          cut;
        int          poke_at;
        kind    = $urandom_range(99);
        width   = ($urandom_range(9) == 0) ? $urandom_range(8, 64) : $urandom_range(1, 7);
        mag     = $urandom_range(1, 5);
        offset  = ($urandom_range(3) == 0) ? 32'(54 + $urandom_range(1, 6)) : 32'd54;
        depth   = $urandom_range(1) ? DEPTH_32 : DEPTH_24;
        cut     = 0;
        poke_at = -1;
        if (kind < 12) begin
            cut = $urandom_range(1, 160);
        end else if (kind < 20) begin
            poke_at = $urandom_range(0, 53);
        end
        if (kind >= 95) begin
            bmp_bytes.delete();
            repeat ($urandom_range(1, 20)) bmp_bytes.push_back(8'($urandom));
            send_file();
        end else begin
            run_file(offset, width, $urandom_range(1) ? -mag : mag, depth,
                     $urandom_range(0, 3), cut, poke_at, 8'($urandom));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Well-formed files: smallest image, 32-bit with skipped bytes and
        // trailing bytes, top-down 24-bit with three pad bytes per row, two and
        // one pad bytes per row, and a file whose last byte is its last pixel.
        run_file(32'd54, 32'd1, 32'd1, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd58, 32'd3, 32'd2, DEPTH_32, 2, 0, -1, 8'h00);
        run_file(32'd54, 32'd3, -32'd3, DEPTH_24, 1, 0, -1, 8'h00);
        run_file(32'd55, 32'd2, 32'd2, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd5, 32'd3, DEPTH_24, 3, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd1, DEPTH_32, 0, 0, -1, 8'h00);

        // A long stretch with no gaps and no stalls covers the header error files.
        gap_pct   = 0;
        stall_pct = 0;

        // Bad signature in either byte, then the rest of the file is ignored.
        run_file(32'd54, 32'd2, 32'd1, DEPTH_24, 0, 0, 0, 8'h43);
        run_file(32'd54, 32'd2, 32'd1, DEPTH_24, 0, 0, 1, 8'h4E);

        // Pixel offset below the header size.
        run_file(32'd53, 32'd2, 32'd1, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd0, 32'd2, 32'd1, DEPTH_24, 0, 0, -1, 8'h00);

        // Width out of range, and the largest width cut after a few pixels.
        run_file(32'd54, 32'd0, 32'd1, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd4097, 32'd1, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd4096, 32'd2, DEPTH_24, 0, 84, -1, 8'h00);

        // Height out of range either way, the most negative height, and the
        // largest top-down height cut after a few pixels.
        run_file(32'd54, 32'd1, 32'd0, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd4097, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, -32'd4097, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'h8000_0000, DEPTH_24, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, -32'd4096, DEPTH_32, 0, 94, -1, 8'h00);

        gap_pct   = 10;
        stall_pct = 10;

        // Unsupported bit counts, one with only the upper byte wrong.
        run_file(32'd54, 32'd1, 32'd1, 16'd16, 0, 0, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd1, 16'h0118, 0, 0, -1, 8'h00);

        // End of file early: on the first byte, inside the header, on a byte
        // that is itself a signature error, on a byte completing a pixel, while
        // skipping to the pixel offset, and on a row pad byte.
        run_file(32'd54, 32'd1, 32'd1, DEPTH_24, 0, 1, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd1, DEPTH_24, 0, 22, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd1, DEPTH_24, 0, 2, 1, 8'h00);
        run_file(32'd54, 32'd2, 32'd2, DEPTH_24, 0, 57, -1, 8'h00);
        run_file(32'd60, 32'd2, 32'd2, DEPTH_24, 0, 57, -1, 8'h00);
        run_file(32'd54, 32'd1, 32'd2, DEPTH_24, 0, 58, -1, 8'h00);

        // Let everything drain before the random files start.
        wait_drained();

        while (bytes_sent < TOTAL_ITEMS) begin
            random_file();
            if ($urandom_range(7) == 0) begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
